FILE: hdl/dlpu_pkg.sv
`timescale 1ns / 1ps

package dlpu_pkg;

    localparam logic [2:0] LIST_NONE = 3'd7;
    localparam logic [2:0] LIST_MAX  = 3'd4;

    // Packet type codes, bits 31:29 of packet word 0.
    localparam logic [2:0] PT_END_LIST = 3'd0;
    localparam logic [2:0] PT_HEADER   = 3'd4;
    localparam logic [2:0] PT_VERTEX   = 3'd7;

    localparam int unsigned KEPT_WORDS = 7;
    localparam logic [31:0] COLOR_WHITE = 32'hffff_ffff;

    typedef enum logic [2:0] {
        K_VERTEX      = 3'd0,
        K_GROUP_START = 3'd1,
        K_LIST_DONE   = 3'd2,
        K_RENDER_DONE = 3'd3,
        K_UNKNOWN     = 3'd4,
        K_NO_LIST     = 3'd5,
        K_GROUP_FULL  = 3'd6,
        K_REJECTED    = 3'd7
    } t_kind;

    // Position within the output sequence of one vertex packet.
    typedef enum logic [1:0] {
        PH_OLDER = 2'd0,
        PH_NEWER = 2'd1,
        PH_FINAL = 2'd2
    } t_phase;

    typedef struct packed {
        logic                          render;
        logic [KEPT_WORDS-1:0][31:0]   words;
    } t_cmd;

    typedef struct packed {
        t_kind       kind;
        logic [2:0]  list_id;
        logic [31:0] pos_x;
        logic [31:0] pos_y;
        logic [31:0] pos_z;
        logic [31:0] tex_u;
        logic [31:0] tex_v;
        logic        textured;
        logic [31:0] color;
        logic        last;
    } t_result;

endpackage

FILE: hdl/dlpu_front.sv
`timescale 1ns / 1ps

module dlpu_front #(
    parameter int PACKET_WORDS = 8
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_stall,
    input  logic            i_func,
    input  logic [31:0]     i_fifo_word,
    input  logic            i_full,
    output logic            o_push,
    output dlpu_pkg::t_cmd  o_cmd
);
    import dlpu_pkg::*;

    localparam int CW = $clog2(PACKET_WORDS);

    logic [CW-1:0]                r_count;
    logic [CW-1:0]                n_count;
    logic [KEPT_WORDS-1:0][31:0]  r_pkt;
    logic                         accept;
    logic                         complete;

    assign o_stall  = i_full;
    assign accept   = i_valid && !i_full;
    assign complete = (r_count == CW'(PACKET_WORDS - 1));
    assign o_push   = accept && (i_func || complete);
    assign o_cmd    = '{render: i_func, words: r_pkt};

    always_comb begin
        n_count = r_count;
        if (accept && !i_func) begin
            n_count = complete ? '0 : r_count + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Only the first seven words of a packet carry anything used downstream.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < KEPT_WORDS; i++) begin
            if (accept && !i_func && r_count == CW'(i)) begin
                r_pkt[i] <= i_fifo_word;
            end
        end
    end

endmodule

FILE: hdl/dlpu_queue.sv
`timescale 1ns / 1ps

module dlpu_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  dlpu_pkg::t_cmd  i_cmd,
    output logic            o_full,
    input  logic            i_pop,
    output logic            o_valid,
    output dlpu_pkg::t_cmd  o_cmd
);
    import dlpu_pkg::*;

    t_cmd       r_mem [2];
    logic       r_wr;
    logic       r_rd;
    logic [1:0] r_cnt;

    assign o_full  = (r_cnt == 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= 1'b0;
            r_rd  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr <= !r_wr;
            end
            if (i_pop) begin
                r_rd <= !r_rd;
            end
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

FILE: hdl/dlpu_back.sv
`timescale 1ns / 1ps

module dlpu_back #(
    parameter int GROUP_CAPACITY = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  dlpu_pkg::t_cmd     i_cmd,
    output logic               o_pop,
    output logic               o_valid,
    input  logic               i_stall,
    output dlpu_pkg::t_result  o_res
);
    import dlpu_pkg::*;

    localparam int GW = $clog2(GROUP_CAPACITY + 1);

    logic             r_valid;
    t_result          r_res;
    t_result          n_res;
    logic [2:0]       r_open, n_open;
    logic [4:0]       r_used, n_used;
    logic [1:0]       r_cfmt, n_cfmt;
    logic             r_tex, n_tex;
    logic [1:0]       r_strip, n_strip;
    logic [5:0][31:0] r_older, n_older;
    logic [5:0][31:0] r_newer, n_newer;
    logic [GW-1:0]    r_gv, n_gv;
    t_phase           r_ph, n_ph;

    logic             step;
    logic             done;
    logic [31:0]      w0;
    logic [2:0]       req;
    logic             room;
    logic             strip_full;
    logic [5:0][31:0] vtx;

    assign step       = i_cmd_valid && (!r_valid || !i_stall);
    assign o_pop      = step && done;
    assign o_valid    = r_valid;
    assign o_res      = r_res;
    assign w0         = i_cmd.words[0];
    assign req        = w0[26:24];
    assign room       = (r_gv < GW'(GROUP_CAPACITY));
    assign strip_full = (r_strip == 2'd3);

    always_comb begin
        vtx[0] = i_cmd.words[1];
        vtx[1] = i_cmd.words[2];
        vtx[2] = i_cmd.words[3];
        vtx[3] = r_tex ? i_cmd.words[4] : 32'd0;
        vtx[4] = r_tex ? i_cmd.words[5] : 32'd0;
        vtx[5] = (r_cfmt == 2'd0) ? i_cmd.words[6] : COLOR_WHITE;
    end

    always_comb begin
        n_res   = '0;
        n_open  = r_open;
        n_used  = r_used;
        n_cfmt  = r_cfmt;
        n_tex   = r_tex;
        n_strip = r_strip;
        n_older = r_older;
        n_newer = r_newer;
        n_gv    = r_gv;
        n_ph    = r_ph;
        done    = 1'b1;
        n_res.last = 1'b1;

        if (i_cmd.render) begin
            n_used = '0;
            n_open = LIST_NONE;
            n_tex  = 1'b0;
            n_res.kind = K_RENDER_DONE;
        end else begin
            case (w0[31:29])
                PT_VERTEX: begin
                    if (r_open == LIST_NONE) begin
                        n_res.kind = K_NO_LIST;
                    end else if (r_ph == PH_OLDER && strip_full && room) begin
                        // Repeat the older strip vertex.
                        n_res = '{K_VERTEX, r_open, r_older[0], r_older[1], r_older[2],
                                  r_older[3], r_older[4], r_tex, r_older[5], 1'b0};
                        n_gv  = r_gv + 1'b1;
                        n_ph  = PH_NEWER;
                        done  = 1'b0;
                    end else if (r_ph != PH_FINAL && strip_full && room) begin
                        n_res = '{K_VERTEX, r_open, r_newer[0], r_newer[1], r_newer[2],
                                  r_newer[3], r_newer[4], r_tex, r_newer[5], 1'b0};
                        n_gv  = r_gv + 1'b1;
                        n_ph  = PH_FINAL;
                        done  = 1'b0;
                    end else if (!room) begin
                        n_res.kind    = K_GROUP_FULL;
                        n_res.list_id = r_open;
                        n_ph          = PH_OLDER;
                    end else begin
                        n_res = '{K_VERTEX, r_open, vtx[0], vtx[1], vtx[2],
                                  vtx[3], vtx[4], r_tex, vtx[5], 1'b1};
                        n_gv  = r_gv + 1'b1;
                        n_ph  = PH_OLDER;
                        if (w0[28]) begin
                            n_strip = 2'd0;
                        end else begin
                            n_older = r_newer;
                            n_newer = vtx;
                            if (!strip_full) begin
                                n_strip = r_strip + 1'b1;
                            end
                        end
                    end
                end
                PT_HEADER: begin
                    n_strip       = 2'd0;
                    n_res.kind    = K_REJECTED;
                    n_res.list_id = req;
                    if (req > LIST_MAX) begin
                        n_res.kind = K_REJECTED;
                    end else if (r_open == LIST_NONE) begin
                        if (!r_used[req]) begin
                            n_open         = req;
                            n_used         = r_used | (5'd1 << req);
                            n_cfmt         = w0[5:4];
                            n_tex          = r_tex | w0[3];
                            n_gv           = '0;
                            n_res.kind     = K_GROUP_START;
                            n_res.textured = r_tex | w0[3];
                        end
                    end else if (r_open == req) begin
                        n_gv           = '0;
                        n_res.kind     = K_GROUP_START;
                        n_res.textured = r_tex;
                    end
                end
                PT_END_LIST: begin
                    if (r_open == LIST_NONE) begin
                        n_res.kind = K_NO_LIST;
                    end else begin
                        n_res.kind    = K_LIST_DONE;
                        n_res.list_id = r_open;
                        n_open        = LIST_NONE;
                    end
                end
                default: begin
                    n_res.kind = K_UNKNOWN;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_open  <= LIST_NONE;
            r_used  <= '0;
            r_cfmt  <= '0;
            r_tex   <= 1'b0;
            r_strip <= '0;
            r_older <= '0;
            r_newer <= '0;
            r_gv    <= '0;
            r_ph    <= PH_OLDER;
        end else begin
            if (step) begin
                r_valid <= 1'b1;
                r_open  <= n_open;
                r_used  <= n_used;
                r_cfmt  <= n_cfmt;
                r_tex   <= n_tex;
                r_strip <= n_strip;
                r_older <= n_older;
                r_newer <= n_newer;
                r_gv    <= n_gv;
                r_ph    <= n_ph;
            end else if (!i_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_res <= n_res;
        end
    end

endmodule

FILE: hdl/display_list_packet_unstripper.sv
`timescale 1ns / 1ps

// Display-list packet unstripper. Command FIFO words enter one per cycle
// (i_func low) and are gathered into packets of PACKET_WORDS words; a start
// render request (i_func high) passes straight through as one item. Each
// finished packet or render request is queued in a two-entry command queue
// and executed by the back end, which emits one result per cycle unless the
// output is stalled: one for most packets and up to three for a vertex once
// a strip holds three vertices, since the two previous strip vertices are
// sent again. Input is taken every cycle unless the command queue is full,
// so words stream at one per cycle and a vertex packet of eight words leaves
// the back end ample time. Results sit in an output register until taken;
// o_last marks the final result of each packet or render request.

module display_list_packet_unstripper #(
    parameter int GROUP_CAPACITY = 1024,
    parameter int PACKET_WORDS   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_fifo_word,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_kind,
    output logic [2:0]  o_list_id,
    output logic [31:0] o_pos_x_bits,
    output logic [31:0] o_pos_y_bits,
    output logic [31:0] o_pos_z_bits,
    output logic [31:0] o_tex_u_bits,
    output logic [31:0] o_tex_v_bits,
    output logic        o_textured,
    output logic [31:0] o_color_argb,
    output logic        o_last
);
    import dlpu_pkg::*;

    logic    full;
    logic    push;
    t_cmd    push_cmd;
    logic    pop;
    logic    cmd_valid;
    t_cmd    cmd;
    t_result res;

    dlpu_front #(.PACKET_WORDS(PACKET_WORDS)) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_fifo_word (i_fifo_word),
        .i_full      (full),
        .o_push      (push),
        .o_cmd       (push_cmd)
    );

    dlpu_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_valid (cmd_valid),
        .o_cmd   (cmd)
    );

    dlpu_back #(.GROUP_CAPACITY(GROUP_CAPACITY)) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (cmd_valid),
        .i_cmd       (cmd),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_res       (res)
    );

    assign o_kind       = res.kind;
    assign o_list_id    = res.list_id;
    assign o_pos_x_bits = res.pos_x;
    assign o_pos_y_bits = res.pos_y;
    assign o_pos_z_bits = res.pos_z;
    assign o_tex_u_bits = res.tex_u;
    assign o_tex_v_bits = res.tex_v;
    assign o_textured   = res.textured;
    assign o_color_argb = res.color;
    assign o_last       = res.last;

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 1ps

// Testbench for the display-list packet unstripper.
//
// A queue of pending items is filled up front by an initial block: a short
// directed part that walks through the special cases of the block, followed
// by random but mostly well-formed display list traffic. A clocked driver
// offers those items to the block, and a clocked monitor checks every result
// against the expectations that the predictor queued when each item was
// accepted. The group capacity is set low so that full groups happen often.

module tb_top;

    import dlpu_pkg::*;

    localparam int CAP   = 16;
    localparam int PKT_W = 8;

    typedef struct {
        bit          func;
        logic [31:0] word;
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic        i_func;
    logic [31:0] i_fifo_word;
    logic        o_valid;
    logic        i_stall;
    logic [2:0]  o_kind;
    logic [2:0]  o_list_id;
    logic [31:0] o_pos_x_bits;
    logic [31:0] o_pos_y_bits;
    logic [31:0] o_pos_z_bits;
    logic [31:0] o_tex_u_bits;
    logic [31:0] o_tex_v_bits;
    logic        o_textured;
    logic [31:0] o_color_argb;
    logic        o_last;

    display_list_packet_unstripper #(
        .GROUP_CAPACITY(CAP),
        .PACKET_WORDS  (PKT_W)
    ) u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_func      (i_func),
        .i_fifo_word (i_fifo_word),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_kind      (o_kind),
        .o_list_id   (o_list_id),
        .o_pos_x_bits(o_pos_x_bits),
        .o_pos_y_bits(o_pos_y_bits),
        .o_pos_z_bits(o_pos_z_bits),
        .o_tex_u_bits(o_tex_u_bits),
        .o_tex_v_bits(o_tex_v_bits),
        .o_textured  (o_textured),
        .o_color_argb(o_color_argb),
        .o_last      (o_last)
    );

    // Pending items, expected results and bookkeeping.
    t_item   pending_items[$];
    t_result expected_results[$];
    int      items_taken;
    int      results_checked;
    int      error_count;
    bit [7:0] kinds_seen;

    // Shadow state of the block, kept by the predictor.
    logic [31:0] pkt[PKT_W];
    int          word_idx;
    logic [2:0]  cur_list;
    logic [4:0]  used_lists;
    logic [1:0]  col_fmt;
    logic        tex_on;
    int          strip_run;
    logic [31:0] older_v[6];
    logic [31:0] newer_v[6];
    int          group_cnt;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Queue one result; vertex data is passed as x, y, z, u, v, color.
    task automatic push_result(input t_kind kind, input logic [2:0] list,
                               input logic [31:0] v[6], input logic tex);
        t_result r;
        r.kind     = kind;
        r.list_id  = list;
        r.pos_x    = v[0];
        r.pos_y    = v[1];
        r.pos_z    = v[2];
        r.tex_u    = v[3];
        r.tex_v    = v[4];
        r.color    = v[5];
        r.textured = tex;
        r.last     = 1'b0;
        expected_results.push_back(r);
    endtask

    // Works out the results of one accepted item and updates the shadow state.
    task automatic predict_item(input logic func, input logic [31:0] word);
        logic [31:0] zero_v[6];
        logic [31:0] v[6];
        logic [2:0]  ptype;
        logic [2:0]  req;
        int          before_cnt;
        before_cnt = expected_results.size();
        for (int i = 0; i < 6; i++) zero_v[i] = '0;
        if (func) begin
            used_lists = '0;
            cur_list   = LIST_NONE;
            tex_on     = 1'b0;
            push_result(K_RENDER_DONE, 3'd0, zero_v, 1'b0);
        end else begin
            pkt[word_idx] = word;
            word_idx++;
            if (word_idx == PKT_W) begin
                word_idx = 0;
                ptype = pkt[0][31:29];
                if (ptype == PT_VERTEX) begin
                    if (cur_list == LIST_NONE) begin
                        push_result(K_NO_LIST, 3'd0, zero_v, 1'b0);
                    end else begin
                        // From the fourth strip vertex on, the two previous
                        // ones go out again if the group still has room.
                        if (strip_run >= 3) begin
                            if (group_cnt < CAP) begin
                                push_result(K_VERTEX, cur_list, older_v, tex_on);
                                group_cnt++;
                            end
                            if (group_cnt < CAP) begin
                                push_result(K_VERTEX, cur_list, newer_v, tex_on);
                                group_cnt++;
                            end
                        end
                        if (group_cnt >= CAP) begin
                            push_result(K_GROUP_FULL, cur_list, zero_v, 1'b0);
                        end else begin
                            v[0] = pkt[1];
                            v[1] = pkt[2];
                            v[2] = pkt[3];
                            v[3] = tex_on ? pkt[4] : 32'd0;
                            v[4] = tex_on ? pkt[5] : 32'd0;
                            v[5] = (col_fmt == 2'd0) ? pkt[6] : COLOR_WHITE;
                            push_result(K_VERTEX, cur_list, v, tex_on);
                            if (pkt[0][28]) begin
                                strip_run = 0;
                            end else begin
                                older_v = newer_v;
                                newer_v = v;
                                if (strip_run < 3) strip_run++;
                            end
                            group_cnt++;
                        end
                    end
                end else if (ptype == PT_HEADER) begin
                    req = pkt[0][26:24];
                    strip_run = 0;
                    if (req > LIST_MAX) begin
                        push_result(K_REJECTED, req, zero_v, 1'b0);
                    end else if (cur_list == LIST_NONE && used_lists[req]) begin
                        push_result(K_REJECTED, req, zero_v, 1'b0);
                    end else if (cur_list != LIST_NONE && cur_list != req) begin
                        push_result(K_REJECTED, req, zero_v, 1'b0);
                    end else begin
                        if (cur_list == LIST_NONE) begin
                            cur_list = req;
                            used_lists[req] = 1'b1;
                            col_fmt = pkt[0][5:4];
                            if (pkt[0][3]) tex_on = 1'b1;
                        end
                        group_cnt = 0;
                        push_result(K_GROUP_START, cur_list, zero_v, tex_on);
                    end
                end else if (ptype == PT_END_LIST) begin
                    if (cur_list == LIST_NONE) begin
                        push_result(K_NO_LIST, 3'd0, zero_v, 1'b0);
                    end else begin
                        push_result(K_LIST_DONE, cur_list, zero_v, 1'b0);
                        cur_list = LIST_NONE;
                    end
                end else begin
                    push_result(K_UNKNOWN, 3'd0, zero_v, 1'b0);
                end
            end
        end
        if (expected_results.size() > before_cnt)
            expected_results[expected_results.size() - 1].last = 1'b1;
    endtask

    // Stimulus helpers. Word 0 is random apart from the fields that are set.
    task automatic add_render();
        t_item it;
        it.func = 1'b1;
        it.word = $urandom;
        pending_items.push_back(it);
    endtask

    task automatic add_packet(input logic [31:0] w0);
        t_item it;
        it.func = 1'b0;
        it.word = w0;
        pending_items.push_back(it);
        for (int i = 1; i < PKT_W; i++) begin
            it.word = $urandom;
            pending_items.push_back(it);
        end
    endtask

    function automatic logic [31:0] header_word(input logic [2:0] list,
                                                input logic tex,
                                                input logic [1:0] fmt);
        logic [31:0] w;
        w = $urandom;
        w[31:29] = PT_HEADER;
        w[26:24] = list;
        w[5:4]   = fmt;
        w[3]     = tex;
        return w;
    endfunction

    function automatic logic [31:0] typed_word(input logic [2:0] ptype,
                                               input logic strip_end);
        logic [31:0] w;
        w = $urandom;
        w[31:29] = ptype;
        w[28]    = strip_end;
        return w;
    endfunction

    // A vertex packet with fixed contents, for the extremes of the fields.
    task automatic add_vertex_fill(input logic [31:0] fill, input logic strip_end);
        t_item it;
        it.func = 1'b0;
        it.word = fill;
        it.word[31:29] = PT_VERTEX;
        it.word[28]    = strip_end;
        pending_items.push_back(it);
        it.word = fill;
        for (int i = 1; i < PKT_W; i++) pending_items.push_back(it);
    endtask

    // The phase of idling follows the count of items taken so far.
    int phase;
    always_comb phase = (items_taken / 70) % 4;

    function automatic int sender_idle_pct(input int ph);
        return (ph == 1) ? 46 : (ph == 3) ? 6 : 0;
    endfunction

    function automatic int receiver_stall_pct(input int ph);
        return (ph == 2) ? 46 : (ph == 3) ? 6 : 0;
    endfunction

    // Driver: an offered item stays put until the block takes it, and the
    // item is handed to the predictor at the edge where it is accepted.
    always @(posedge i_clk) begin
        t_item it;
        if (!i_rst_n) begin
            i_valid     <= 1'b0;
            i_func      <= 1'b0;
            i_fifo_word <= '0;
        end else begin
            if (i_valid && !o_stall) begin
                predict_item(i_func, i_fifo_word);
                items_taken <= items_taken + 1;
            end
            if (!i_valid || !o_stall) begin
                if (pending_items.size() > 0 &&
                    $urandom_range(0, 99) >= sender_idle_pct(phase)) begin
                    it = pending_items.pop_front();
                    i_valid     <= 1'b1;
                    i_func      <= it.func;
                    i_fifo_word <= it.word;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Long hold-off: once, the receiver stops taking results while the sender
    // keeps offering, so the block backs up.
    int  hold_left;
    bit  hold_done;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (!hold_done && items_taken >= 120) begin
            hold_left <= 300;
            hold_done <= 1'b1;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n)
            i_stall <= 1'b0;
        else
            i_stall <= (hold_left > 1) ||
                       ($urandom_range(0, 99) < receiver_stall_pct(phase));
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge i_clk) begin
        t_result e;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result: kind %0d list %0d", o_kind, o_list_id);
                error_count++;
            end else begin
                e = expected_results.pop_front();
                results_checked++;
                kinds_seen[o_kind] = 1'b1;
                if (o_kind !== e.kind) begin
                    $error("kind: expected %0d, got %0d", e.kind, o_kind);
                    error_count++;
                end
                if (o_list_id !== e.list_id) begin
                    $error("list_id: expected %0d, got %0d", e.list_id, o_list_id);
                    error_count++;
                end
                if (o_pos_x_bits !== e.pos_x) begin
                    $error("pos_x_bits: expected %h, got %h", e.pos_x, o_pos_x_bits);
                    error_count++;
                end
                if (o_pos_y_bits !== e.pos_y) begin
                    $error("pos_y_bits: expected %h, got %h", e.pos_y, o_pos_y_bits);
                    error_count++;
                end
                if (o_pos_z_bits !== e.pos_z) begin
                    $error("pos_z_bits: expected %h, got %h", e.pos_z, o_pos_z_bits);
                    error_count++;
                end
                if (o_tex_u_bits !== e.tex_u) begin
                    $error("tex_u_bits: expected %h, got %h", e.tex_u, o_tex_u_bits);
                    error_count++;
                end
                if (o_tex_v_bits !== e.tex_v) begin
                    $error("tex_v_bits: expected %h, got %h", e.tex_v, o_tex_v_bits);
                    error_count++;
                end
                if (o_textured !== e.textured) begin
                    $error("textured: expected %0d, got %0d", e.textured, o_textured);
                    error_count++;
                end
                if (o_color_argb !== e.color) begin
                    $error("color_argb: expected %h, got %h", e.color, o_color_argb);
                    error_count++;
                end
                if (o_last !== e.last) begin
                    $error("last: expected %0d, got %0d", e.last, o_last);
                    error_count++;
                end
            end
        end
    end

    // Stimulus, reset and the end of the run.
    initial begin
        int r;
        int target;
        logic [2:0] gen_list;
        i_rst_n     = 1'b0;
        items_taken = 0;
        results_checked = 0;
        error_count = 0;
        kinds_seen  = '0;
        word_idx    = 0;
        cur_list    = LIST_NONE;
        used_lists  = '0;
        col_fmt     = '0;
        tex_on      = 1'b0;
        strip_run   = 0;
        group_cnt   = 0;
        for (int i = 0; i < 6; i++) begin
            older_v[i] = '0;
            newer_v[i] = '0;
        end

        // Directed part: the error paths first, then a textured strip long
        // enough to repeat vertices, with all-zero and all-one contents.
        add_render();
        add_packet(typed_word(PT_VERTEX, 1'b0));        // vertex, no list open
        add_packet(typed_word(PT_END_LIST, 1'b0));      // end list, none open
        add_packet(header_word(3'd5, 1'b0, 2'd0));      // list id out of range
        add_packet(header_word(3'd0, 1'b1, 2'd0));      // open opaque, textured
        add_vertex_fill(32'h0000_0000, 1'b0);
        add_vertex_fill(32'hffff_ffff, 1'b0);
        add_vertex_fill(32'h0000_0000, 1'b0);
        add_vertex_fill(32'hffff_ffff, 1'b0);           // repeats the previous two
        add_vertex_fill(32'h5a5a_a5a5, 1'b1);           // end of strip
        add_packet(header_word(3'd2, 1'b0, 2'd0));      // another list while one open
        add_packet(typed_word(3'd1, 1'b0));             // unknown packet type
        add_packet(typed_word(PT_END_LIST, 1'b0));
        add_packet(header_word(3'd0, 1'b0, 2'd1));      // list already used
        add_packet(header_word(3'd4, 1'b0, 2'd3));      // punch-through, white color
        add_vertex_fill(32'h1234_5678, 1'b0);
        add_render();
        add_packet(header_word(3'd7, 1'b0, 2'd0));

        // Random part: mostly well-formed lists with random content, until at
        // least 480 items are pending in all.
        target   = 480;
        gen_list = LIST_NONE;
        while (pending_items.size() < target) begin
            r = $urandom_range(0, 99);
            if (r < 5) begin
                add_render();
                gen_list = LIST_NONE;
            end else if (r < 12) begin
                add_packet($urandom);                   // any packet type
            end else if (r < 15) begin
                // A render request in the middle of a packet keeps the
                // words already gathered.
                t_item it;
                it.func = 1'b0;
                it.word = typed_word(PT_VERTEX, 1'($urandom_range(0, 1)));
                pending_items.push_back(it);
                for (int i = 1; i < 3; i++) begin
                    it.word = $urandom;
                    pending_items.push_back(it);
                end
                add_render();
                gen_list = LIST_NONE;
                for (int i = 3; i < PKT_W; i++) begin
                    it.word = $urandom;
                    pending_items.push_back(it);
                end
            end else if (r < 30) begin
                if (gen_list == LIST_NONE || $urandom_range(0, 3) == 0)
                    gen_list = ($urandom_range(0, 9) == 0) ? 3'($urandom_range(5, 7))
                                                           : 3'($urandom_range(0, 4));
                add_packet(header_word(gen_list, 1'($urandom_range(0, 1)),
                                       2'($urandom_range(0, 3))));
            end else if (r < 38) begin
                add_packet(typed_word(PT_END_LIST, 1'b0));
                gen_list = LIST_NONE;
            end else begin
                add_packet(typed_word(PT_VERTEX, $urandom_range(0, 99) < 12));
            end
        end

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        wait (pending_items.size() == 0);
        @(posedge i_clk);
        while (i_valid) @(posedge i_clk);
        while (expected_results.size() > 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("Checked %0d results from %0d items; result kinds seen: %b.",
                 results_checked, items_taken, kinds_seen);
        if (error_count == 0 && expected_results.size() == 0) begin
            $display("tb_top: done, clean");
        end else begin
            $display("tb_top: done, errors");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Run timed out with %0d results still expected.",
                 expected_results.size());
        $display("tb_top: done, errors");
        $finish;
    end

endmodule
